### rtl/cc2ansi_pkg.sv
// shared types, constants and helper functions of the caret color translator
`default_nettype none

package cc2ansi_pkg;

  localparam int LitMax  = 8;
  localparam int LitIdxW = $clog2(LitMax);
  localparam int LitCntW = $clog2(LitMax + 1);
  localparam int HexLen  = 6;
  localparam int HexCntW = 3;
  localparam int QDepth  = 2;
  localparam int QPtrW   = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW   = $clog2(QDepth + 1);

  localparam logic [7:0] ChCaret = 8'h5E;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChRst   = 8'h72;
  localparam logic [7:0] ChEsc   = 8'h1B;
  localparam logic [7:0] ChLbr   = 8'h5B;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChM     = 8'h6D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChTwo   = 8'h32;
  localparam logic [7:0] ChThree = 8'h33;
  localparam logic [7:0] ChEight = 8'h38;

  localparam logic [1:0] DigTerm = 2'd3;
  localparam logic [1:0] FldLast = 2'd2;

  typedef logic [LitMax-1:0][7:0] lit_t;
  typedef logic [HexLen-1:0][7:0] hexbuf_t;

  // decimal digits of one color channel, dig[0] is the hundreds digit
  typedef struct packed {
    logic [1:0]      ndig;
    logic [2:0][3:0] dig;
  } dec_t;

  typedef struct packed {
    logic [LitCntW-1:0] lit_n;
    lit_t               lit;
    logic               col;
    dec_t [2:0]         rgb;
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } qpush_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qhead_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef enum logic {
    PH_LIT,
    PH_FLD
  } phase_e;

  // binary to decimal by shift and add-3
  function automatic dec_t to_dec(input logic [7:0] v);
    logic [19:0] sh;
    dec_t        res;
    sh = {12'd0, v};
    for (int i = 0; i < 8; i++) begin
      if (sh[11:8] >= 4'd5) sh[11:8] = sh[11:8] + 4'd3;
      if (sh[15:12] >= 4'd5) sh[15:12] = sh[15:12] + 4'd3;
      if (sh[19:16] >= 4'd5) sh[19:16] = sh[19:16] + 4'd3;
      sh = sh << 1;
    end
    res.dig[0] = sh[19:16];
    res.dig[1] = sh[15:12];
    res.dig[2] = sh[11:8];
    if (sh[19:16] != 4'd0) res.ndig = 2'd3;
    else if (sh[15:12] != 4'd0) res.ndig = 2'd2;
    else res.ndig = 2'd1;
    return res;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) t = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h66) t = c - 8'h57;
    else if (c >= 8'h41 && c <= 8'h46) t = c - 8'h37;
    return t[3:0];
  endfunction

  function automatic rgb_t color_lookup(input logic [7:0] c);
    rgb_t res;
    res = '0;
    res.hit = 1'b1;
    case (c)
      8'h30:   begin res.r = 8'd0;   res.g = 8'd0;   res.b = 8'd0;   end
      8'h31:   begin res.r = 8'd255; res.g = 8'd64;  res.b = 8'd64;  end
      8'h32:   begin res.r = 8'd64;  res.g = 8'd255; res.b = 8'd64;  end
      8'h33:   begin res.r = 8'd255; res.g = 8'd255; res.b = 8'd64;  end
      8'h34:   begin res.r = 8'd64;  res.g = 8'd128; res.b = 8'd255; end
      8'h35:   begin res.r = 8'd64;  res.g = 8'd255; res.b = 8'd255; end
      8'h36:   begin res.r = 8'd255; res.g = 8'd64;  res.b = 8'd255; end
      8'h37:   begin res.r = 8'd200; res.g = 8'd200; res.b = 8'd195; end
      8'h67:   begin res.r = 8'd183; res.g = 8'd110; res.b = 8'd121; end
      8'h64:   begin res.r = 8'd40;  res.g = 8'd40;  res.b = 8'd38;  end
      default: res.hit = 1'b0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/cc2ansi_in_if.sv
// input character channel
`default_nettype none

interface cc2ansi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       msg_last;

  modport source (output valid, output in_char, output msg_last, input ready);
  modport sink (input valid, input in_char, input msg_last, output ready);
endinterface

`default_nettype wire

### rtl/cc2ansi_out_if.sv
// output byte channel
`default_nettype none

interface cc2ansi_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       msg_end;

  modport source (output valid, output out_byte, output run_last, output msg_end,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input msg_end,
                output ready);
endinterface

`default_nettype wire

### rtl/cc2ansi_front.sv
// front end: parses caret codes and turns the input characters into emit commands
`default_nettype none

module cc2ansi_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  cc2ansi_in_if.sink           in_i,
  input  logic                 q_ready_i,
  output cc2ansi_pkg::qpush_t  push_o
);
  import cc2ansi_pkg::*;

  logic               en_q;
  logic               caret_q, caret_d;
  logic               hexm_q, hexm_d;
  logic [HexCntW-1:0] cnt_q, cnt_d;
  hexbuf_t            hex_chars_q;
  hexbuf_t            chars_w;
  logic               acc;
  logic               wr_hex;
  logic               emit;
  logic               tail;
  logic [7:0]         c;
  logic               last;
  rgb_t               lk;
  cmd_t               cmd;

  function automatic cmd_t mk_lit1(input logic [7:0] b);
    cmd_t res;
    res        = '0;
    res.lit_n  = LitCntW'(1);
    res.lit[0] = b;
    return res;
  endfunction

  function automatic cmd_t mk_lit2(input logic [7:0] a, input logic [7:0] b);
    cmd_t res;
    res        = '0;
    res.lit_n  = LitCntW'(2);
    res.lit[0] = a;
    res.lit[1] = b;
    return res;
  endfunction

  function automatic cmd_t mk_reset();
    cmd_t res;
    res        = '0;
    res.lit_n  = LitCntW'(4);
    res.lit[0] = ChEsc;
    res.lit[1] = ChLbr;
    res.lit[2] = ChZero;
    res.lit[3] = ChM;
    return res;
  endfunction

  function automatic cmd_t mk_color(input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b);
    cmd_t res;
    res        = '0;
    res.lit_n  = LitCntW'(7);
    res.lit[0] = ChEsc;
    res.lit[1] = ChLbr;
    res.lit[2] = ChThree;
    res.lit[3] = ChEight;
    res.lit[4] = ChSemi;
    res.lit[5] = ChTwo;
    res.lit[6] = ChSemi;
    res.col    = 1'b1;
    res.rgb[0] = to_dec(r);
    res.rgb[1] = to_dec(g);
    res.rgb[2] = to_dec(b);
    return res;
  endfunction

  // caret, hash, the collected digits and an optional trailing byte
  function automatic cmd_t mk_flush(input hexbuf_t chars, input logic [HexCntW-1:0] n,
                                    input logic has_x, input logic [7:0] x);
    cmd_t res;
    res        = '0;
    res.lit[0] = ChCaret;
    res.lit[1] = ChHash;
    for (int k = 0; k < HexLen; k++) begin
      res.lit[k+2] = (k < int'(n)) ? chars[k] : x;
    end
    res.lit_n = LitCntW'(2) + LitCntW'(n) + LitCntW'(has_x);
    return res;
  endfunction

  assign acc         = in_i.valid && in_i.ready;
  assign in_i.ready  = q_ready_i;
  assign c           = in_i.in_char;
  assign last        = in_i.msg_last;
  assign push_o.push = acc && emit;
  assign push_o.cmd  = cmd;

  always_comb begin
    chars_w = hex_chars_q;
    if (cnt_q < HexCntW'(HexLen)) chars_w[cnt_q] = c;
    lk      = color_lookup(c);
    emit    = 1'b0;
    cmd     = '0;
    tail    = 1'b0;
    wr_hex  = 1'b0;
    caret_d = caret_q;
    hexm_d  = hexm_q;
    cnt_d   = cnt_q;

    if (!en_q) begin
      emit    = 1'b1;
      cmd     = mk_lit1(c);
      caret_d = 1'b0;
      hexm_d  = 1'b0;
      cnt_d   = '0;
    end else if (hexm_q) begin
      if (is_hex(c)) begin
        wr_hex = 1'b1;
        if (cnt_q == HexCntW'(HexLen - 1)) begin
          emit   = 1'b1;
          cmd    = mk_color({hex_val(chars_w[0]), hex_val(chars_w[1])},
                            {hex_val(chars_w[2]), hex_val(chars_w[3])},
                            {hex_val(chars_w[4]), hex_val(chars_w[5])});
          hexm_d = 1'b0;
          cnt_d  = '0;
        end else if (last) begin
          emit = 1'b1;
          cmd  = mk_flush(chars_w, cnt_q + HexCntW'(1), 1'b0, c);
        end else begin
          cnt_d = cnt_q + HexCntW'(1);
        end
      end else begin
        // failed hex run: dump it, then the character is handled as plain input
        hexm_d = 1'b0;
        cnt_d  = '0;
        tail   = !(c == ChCaret && !last);
        if (!tail) caret_d = 1'b1;
        emit   = 1'b1;
        cmd    = mk_flush(hex_chars_q, cnt_q, tail, c);
      end
    end else if (caret_q) begin
      caret_d = 1'b0;
      if (c == ChHash) begin
        if (last) begin
          emit = 1'b1;
          cmd  = mk_lit2(ChCaret, ChHash);
        end else begin
          hexm_d = 1'b1;
          cnt_d  = '0;
        end
      end else if (c == ChRst) begin
        emit = 1'b1;
        cmd  = mk_reset();
      end else if (c == ChCaret) begin
        emit = 1'b1;
        cmd  = mk_lit1(ChCaret);
      end else if (lk.hit) begin
        emit = 1'b1;
        cmd  = mk_color(lk.r, lk.g, lk.b);
      end else begin
        emit = 1'b1;
        cmd  = mk_lit2(ChCaret, c);
      end
    end else begin
      if (c == ChCaret && !last) caret_d = 1'b1;
      else begin
        emit = 1'b1;
        cmd  = mk_lit1(c);
      end
    end

    if (last) begin
      caret_d = 1'b0;
      hexm_d  = 1'b0;
      cnt_d   = '0;
    end
    cmd.last = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q    <= 1'b1;
      caret_q <= 1'b0;
      hexm_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      if (cfg_we_i) en_q <= cfg_wdata_i;
      if (acc) begin
        caret_q <= caret_d;
        hexm_q  <= hexm_d;
        cnt_q   <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && wr_hex) hex_chars_q[cnt_q] <= c;
  end

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && last |=> !caret_q && !hexm_q && cnt_q == '0)
    else $error("parser state not idle after end of message");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != '0 |-> hexm_q && cnt_q < HexCntW'(HexLen))
    else $error("hex digit count outside a hex run");

endmodule

`default_nettype wire

### rtl/cc2ansi_queue.sv
// short command queue between front end and byte sequencer
`default_nettype none

module cc2ansi_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cc2ansi_pkg::qpush_t push_i,
  output logic                ready_o,
  input  logic                pop_i,
  output cc2ansi_pkg::qhead_t head_o
);
  import cc2ansi_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  function automatic logic [QPtrW-1:0] wrap_inc(input logic [QPtrW-1:0] p);
    return (p == QPtrW'(QDepth - 1)) ? '0 : p + QPtrW'(1);
  endfunction

  assign ready_o      = (cnt_q != QCntW'(QDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i.push) wr_ptr_q <= wrap_inc(wr_ptr_q);
      if (pop_i) rd_ptr_q <= wrap_inc(rd_ptr_q);
      if (push_i.push && !pop_i) cnt_q <= cnt_q + QCntW'(1);
      else if (!push_i.push && pop_i) cnt_q <= cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) mem_q[wr_ptr_q] <= push_i.cmd;
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.push |-> cnt_q != QCntW'(QDepth)) and (pop_i |-> cnt_q != '0))
    else $error("command queue overflow or underflow");

endmodule

`default_nettype wire

### rtl/cc2ansi_back.sv
// back end: walks one command and emits its bytes through the output register
`default_nettype none

module cc2ansi_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cc2ansi_pkg::qhead_t head_i,
  output logic                pop_o,
  cc2ansi_out_if.source       out_o
);
  import cc2ansi_pkg::*;

  phase_e             phase_q, phase_d;
  logic [LitIdxW-1:0] idx_q, idx_d;
  logic [1:0]         fld_q, fld_d;
  logic [1:0]         dig_q, dig_d;
  logic [1:0]         fld_n;
  logic               ov_q;
  logic [7:0]         byte_q, byte_d;
  logic               rl_q, me_q;
  logic               fire;
  logic               done;
  cmd_t               cmd;
  dec_t               dcur;

  assign cmd   = head_i.cmd;
  assign fire  = head_i.valid && (!ov_q || out_o.ready);
  assign fld_n = fld_q + 2'd1;
  assign dcur  = cmd.rgb[fld_q];
  assign pop_o = fire && done;

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    fld_d   = fld_q;
    dig_d   = dig_q;
    byte_d  = 8'd0;
    done    = 1'b0;
    if (phase_q == PH_LIT) begin
      byte_d = cmd.lit[idx_q];
      if (LitCntW'(idx_q) == cmd.lit_n - LitCntW'(1)) begin
        if (cmd.col) begin
          phase_d = PH_FLD;
          fld_d   = 2'd0;
          dig_d   = DigTerm - cmd.rgb[0].ndig;
        end else begin
          done = 1'b1;
        end
      end else begin
        idx_d = idx_q + LitIdxW'(1);
      end
    end else begin
      if (dig_q != DigTerm) begin
        byte_d = {4'h3, dcur.dig[dig_q]};
        dig_d  = dig_q + 2'd1;
      end else if (fld_q == FldLast) begin
        byte_d = ChM;
        done   = 1'b1;
      end else begin
        // separator, then skip the leading zeros of the next channel
        byte_d = ChSemi;
        fld_d  = fld_n;
        dig_d  = DigTerm - cmd.rgb[fld_n].ndig;
      end
    end
    if (done) begin
      phase_d = PH_LIT;
      idx_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LIT;
      idx_q   <= '0;
      fld_q   <= '0;
      dig_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (fire) begin
        phase_q <= phase_d;
        idx_q   <= idx_d;
        fld_q   <= fld_d;
        dig_q   <= dig_d;
        ov_q    <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      byte_q <= byte_d;
      rl_q   <= done;
      me_q   <= done && cmd.last;
    end
  end

  assign out_o.valid    = ov_q;
  assign out_o.out_byte = byte_q;
  assign out_o.run_last = rl_q;
  assign out_o.msg_end  = me_q;

  a_fld_has_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_FLD |-> head_i.valid && cmd.col && fld_q != 2'd3)
    else $error("color sequencing without a color command at the head");

  a_lit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_i.valid && phase_q == PH_LIT |-> LitCntW'(idx_q) < cmd.lit_n)
    else $error("literal index past the end of the command");

endmodule

`default_nettype wire

### rtl/caret_color_to_ansi_translator.sv
// top level of the caret color code to ansi truecolor translator
//
//  channel    dir  handshake      payload
//  in_i       in   valid/ready    in_char[7:0], msg_last
//  out_o      out  valid/ready    out_byte[7:0], run_last, msg_end
//  ansi_en    in   write enable   ansi_enable_wdata_i (1 bit, reset 1)
//
// a code expands into 1 to 19 bytes, one per cycle while out_o is ready, set by the byte
// sequencer in the back end, which works one command at a time
// the front end keeps taking characters while the 2-entry command queue has room
// characters that only change parser state (caret, hash, hex digits) make no beat;
// reset is asynchronous and leaves nothing to sweep
`default_nettype none

module caret_color_to_ansi_translator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          ansi_enable_we_i,
  input  logic          ansi_enable_wdata_i,
  cc2ansi_in_if.sink    in_i,
  cc2ansi_out_if.source out_o
);
  import cc2ansi_pkg::*;

  qpush_t push;
  qhead_t head;
  logic   q_ready;
  logic   pop;

  cc2ansi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (ansi_enable_we_i),
    .cfg_wdata_i (ansi_enable_wdata_i),
    .in_i        (in_i),
    .q_ready_i   (q_ready),
    .push_o      (push)
  );

  cc2ansi_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ready_o (q_ready),
    .pop_i   (pop),
    .head_o  (head)
  );

  cc2ansi_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire
